/* rtl/core/mchw_pkg.sv */
// Shared types and constants for the multi-channel health watchdog.
// No dependencies; used by mchw_chan_chk and the top level.
`default_nettype none

package mchw_pkg;

  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned NUM_REGS = 2 * NUM_CH;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_FAST = 32'd500;
  localparam logic [LIMIT_W-1:0] LIMIT_SLOW = 32'd1000;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_BEAT   = 2'd1,
    REQ_REPORT = 2'd2
  } req_type_t;

endpackage

`default_nettype wire

/* rtl/core/mchw_chan_chk.sv */
// Health check of one channel: heartbeat age, function flag and report age.
// Depends on mchw_pkg for the limit width.
`default_nettype none

module mchw_chan_chk #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  wire logic [TICK_WIDTH-1:0]       tick_now,
  input  wire logic [TICK_WIDTH-1:0]       beat_stamp,
  input  wire logic [TICK_WIDTH-1:0]       report_stamp,
  input  wire logic                        report_ok,
  input  wire logic [mchw_pkg::LIMIT_W-1:0] hb_limit,
  input  wire logic [mchw_pkg::LIMIT_W-1:0] fn_limit,
  output logic                             healthy
);

  localparam int unsigned CMP_W =
      (TICK_WIDTH > mchw_pkg::LIMIT_W) ? TICK_WIDTH : mchw_pkg::LIMIT_W;

  logic [TICK_WIDTH-1:0] beat_age;
  logic [TICK_WIDTH-1:0] report_age;
  logic                  beat_late;
  logic                  report_late;

  // Ages wrap modulo the counter width, so a plain subtraction suffices.
  assign beat_age    = tick_now - beat_stamp;
  assign report_age  = tick_now - report_stamp;
  assign beat_late   = CMP_W'(beat_age) > CMP_W'(hb_limit);
  assign report_late = CMP_W'(report_age) > CMP_W'(fn_limit);
  assign healthy     = !beat_late && report_ok && !report_late;

endmodule

`default_nettype wire

/* rtl/core/multi_channel_health_watchdog_unit.sv */
// Top level of the three-channel heartbeat and function-report watchdog.
// Depends on mchw_pkg and mchw_chan_chk.
//
// Each accepted request (a tick, a heartbeat or a function report) updates the
// tick counter or the channel's time stamps at the edge that accepts it, and
// one result follows: all_healthy, set when every channel's heartbeat age and
// report age are within their limits and its last function flag was good.
// Acceptance loads the state registers and chk_valid_r; three parallel channel
// checks, two subtracts and compares each, feed the result register, so a new
// request is taken every cycle unless the output stalls. Timeout registers are
// written via the plain write port by the user, only while idle; not enforced.
`default_nettype none

module multi_channel_health_watchdog_unit #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,  // chan_index[1:0], status_good[2]
  input  wire logic [1:0]                        in_tuser,  // req_type[1:0]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [7:0]                             out_tdata, // all_healthy[0]
  input  wire logic                              cfg_we,
  input  wire logic [mchw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mchw_pkg::LIMIT_W-1:0]      cfg_wdata
);

  localparam int unsigned NCH = mchw_pkg::NUM_CH;

  logic [TICK_WIDTH-1:0]            tick_r;
  logic [TICK_WIDTH-1:0]            beat_r   [NCH];
  logic [TICK_WIDTH-1:0]            rpt_r    [NCH];
  logic                             ok_r     [NCH];
  logic [mchw_pkg::LIMIT_W-1:0]     hb_lim_r [NCH];
  logic [mchw_pkg::LIMIT_W-1:0]     fn_lim_r [NCH];

  logic                             chk_valid_r;
  logic                             out_valid_r;
  logic                             healthy_r;
  logic                             healthy_nxt;
  logic [NCH-1:0]                   ch_ok;

  logic                             in_acc;
  logic                             chk_adv;
  logic [mchw_pkg::CH_W-1:0]        in_ch;
  logic                             in_good;
  mchw_pkg::req_type_t              in_req;
  logic [mchw_pkg::CH_W-1:0]        cfg_ch;

  assign in_ch   = in_tdata[1:0];
  assign in_good = in_tdata[2];
  assign in_req  = mchw_pkg::req_type_t'(in_tuser);
  assign cfg_ch  = cfg_index[mchw_pkg::CFG_IDX_W-1:1];

  assign chk_adv   = chk_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !chk_valid_r || chk_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        beat_r[i] <= '0;
        rpt_r[i]  <= '0;
        ok_r[i]   <= 1'b1;
      end
      hb_lim_r[0] <= mchw_pkg::LIMIT_FAST;
      fn_lim_r[0] <= mchw_pkg::LIMIT_FAST;
      hb_lim_r[1] <= mchw_pkg::LIMIT_FAST;
      fn_lim_r[1] <= mchw_pkg::LIMIT_FAST;
      hb_lim_r[2] <= mchw_pkg::LIMIT_SLOW;
      fn_lim_r[2] <= mchw_pkg::LIMIT_SLOW;
    end else begin
      if (cfg_we && (cfg_index < mchw_pkg::CFG_IDX_W'(mchw_pkg::NUM_REGS))) begin
        if (cfg_index[0]) begin
          fn_lim_r[cfg_ch] <= cfg_wdata;
        end else begin
          hb_lim_r[cfg_ch] <= cfg_wdata;
        end
      end
      if (in_acc) begin
        case (in_req)
          mchw_pkg::REQ_TICK: begin
            tick_r <= tick_r + 1'b1;
          end
          mchw_pkg::REQ_BEAT: begin
            if (in_ch < mchw_pkg::CH_W'(NCH)) begin
              beat_r[in_ch] <= tick_r;
            end
          end
          mchw_pkg::REQ_REPORT: begin
            if (in_ch < mchw_pkg::CH_W'(NCH)) begin
              rpt_r[in_ch] <= tick_r;
              ok_r[in_ch]  <= in_good;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  for (genvar g = 0; g < NCH; g++) begin : g_chk
    mchw_chan_chk #(
      .TICK_WIDTH(TICK_WIDTH)
    ) u_chk (
      .tick_now    (tick_r),
      .beat_stamp  (beat_r[g]),
      .report_stamp(rpt_r[g]),
      .report_ok   (ok_r[g]),
      .hb_limit    (hb_lim_r[g]),
      .fn_limit    (fn_lim_r[g]),
      .healthy     (ch_ok[g])
    );
  end

  assign healthy_nxt = &ch_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        chk_valid_r <= 1'b1;
      end else if (chk_adv) begin
        chk_valid_r <= 1'b0;
      end
      if (chk_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_adv) begin
      healthy_r <= healthy_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, healthy_r};

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for multi_channel_health_watchdog_unit.
// Runs a directed table and then random tick, heartbeat and report requests, and checks
// every result against the table or a predictor. Uses only mchw_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TICK_W = 32;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CH_OUT_OF_RANGE = 2'd3;
  localparam logic [mchw_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef enum logic [mchw_pkg::CFG_IDX_W-1:0] {
    REG_HB_CH0, REG_FN_CH0, REG_HB_CH1, REG_FN_CH1, REG_HB_CH2, REG_FN_CH2
  } limit_reg_t;

  typedef enum logic [1:0] {LIM_RESET, LIM_ZERO, LIM_MAX} limit_set_t;

  typedef struct packed {
    limit_set_t lim;
    logic [1:0] req;
    logic [1:0] chan;
    logic       good;
    logic       healthy;
  } directed_row_t;

  localparam int N_DIRECTED = 21;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{LIM_RESET, mchw_pkg::REQ_TICK,   2'd0,            1'b0, 1'b1},
    '{LIM_RESET, mchw_pkg::REQ_REPORT, 2'd0,            1'b0, 1'b0},
    '{LIM_RESET, mchw_pkg::REQ_REPORT, 2'd1,            1'b1, 1'b0},
    '{LIM_RESET, mchw_pkg::REQ_REPORT, 2'd0,            1'b1, 1'b1},
    '{LIM_RESET, mchw_pkg::REQ_BEAT,   CH_OUT_OF_RANGE, 1'b1, 1'b1},
    '{LIM_RESET, mchw_pkg::REQ_REPORT, CH_OUT_OF_RANGE, 1'b0, 1'b1},
    '{LIM_RESET, REQ_UNUSED,           2'd2,            1'b1, 1'b1},
    '{LIM_RESET, mchw_pkg::REQ_TICK,   CH_OUT_OF_RANGE, 1'b1, 1'b1},
    '{LIM_RESET, mchw_pkg::REQ_BEAT,   2'd2,            1'b0, 1'b1},
    '{LIM_RESET, mchw_pkg::REQ_REPORT, 2'd2,            1'b0, 1'b0},
    '{LIM_RESET, mchw_pkg::REQ_TICK,   2'd1,            1'b0, 1'b0},
    '{LIM_RESET, mchw_pkg::REQ_REPORT, 2'd2,            1'b1, 1'b1},
    '{LIM_ZERO,  mchw_pkg::REQ_BEAT,   2'd0,            1'b0, 1'b0},
    '{LIM_ZERO,  mchw_pkg::REQ_BEAT,   2'd1,            1'b0, 1'b0},
    '{LIM_ZERO,  mchw_pkg::REQ_BEAT,   2'd2,            1'b1, 1'b0},
    '{LIM_ZERO,  mchw_pkg::REQ_REPORT, 2'd0,            1'b1, 1'b0},
    '{LIM_ZERO,  mchw_pkg::REQ_REPORT, 2'd1,            1'b1, 1'b1},
    '{LIM_ZERO,  mchw_pkg::REQ_TICK,   2'd0,            1'b1, 1'b0},
    '{LIM_MAX,   mchw_pkg::REQ_REPORT, 2'd1,            1'b0, 1'b0},
    '{LIM_MAX,   mchw_pkg::REQ_REPORT, 2'd1,            1'b1, 1'b1},
    '{LIM_MAX,   mchw_pkg::REQ_TICK,   2'd2,            1'b1, 1'b1}
  };

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;   // chan_index[1:0], status_good[2]
  logic [1:0]         in_tuser;   // req_type[1:0]
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;  // all_healthy[0]
  logic               cfg_we;
  logic [mchw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mchw_pkg::LIMIT_W-1:0] cfg_wdata;

  logic [TICK_W-1:0]  tick_cnt;
  logic [TICK_W-1:0]  beat_stamp [mchw_pkg::NUM_CH];
  logic [TICK_W-1:0]  report_stamp [mchw_pkg::NUM_CH];
  logic               report_ok [mchw_pkg::NUM_CH];
  logic [mchw_pkg::LIMIT_W-1:0] beat_limit [mchw_pkg::NUM_CH];
  logic [mchw_pkg::LIMIT_W-1:0] report_limit [mchw_pkg::NUM_CH];

  logic healthy_q [$];
  int   mismatch_cnt = 0;
  bit   calm = 1'b0;
  int   ready_hold = 0;

  multi_channel_health_watchdog_unit #(.TICK_WIDTH(TICK_W)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("multi_channel_health_watchdog_unit test failed");
    $finish;
  end

  function automatic logic next_all_healthy(input logic [1:0] req, input logic [1:0] chan,
                                            input logic good);
    logic [TICK_W-1:0] beat_age;
    logic [TICK_W-1:0] report_age;
    logic              ok;
    ok = 1'b1;
    if (req == mchw_pkg::REQ_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
    end else if (req == mchw_pkg::REQ_BEAT && chan < mchw_pkg::NUM_CH) begin
      beat_stamp[chan] = tick_cnt;
    end else if (req == mchw_pkg::REQ_REPORT && chan < mchw_pkg::NUM_CH) begin
      report_ok[chan] = good;
      report_stamp[chan] = tick_cnt;
    end
    for (int c = 0; c < mchw_pkg::NUM_CH; c++) begin
      beat_age = tick_cnt - beat_stamp[c];
      report_age = tick_cnt - report_stamp[c];
      if (beat_age > beat_limit[c] || !report_ok[c] || report_age > report_limit[c]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic write_reg(input limit_reg_t idx, input logic [mchw_pkg::LIMIT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_limits();
    write_reg(REG_HB_CH0, beat_limit[0]);
    write_reg(REG_FN_CH0, report_limit[0]);
    write_reg(REG_HB_CH1, beat_limit[1]);
    write_reg(REG_FN_CH1, report_limit[1]);
    write_reg(REG_HB_CH2, beat_limit[2]);
    write_reg(REG_FN_CH2, report_limit[2]);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (healthy_q.size() != 0);
  endtask

  task automatic send_req(input logic [1:0] req, input logic [1:0] chan, input logic good,
                          input logic use_typed, input logic typed_healthy);
    int   gap;
    logic predicted;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'b0, good, chan};
    do @(posedge clk); while (!in_tready);
    predicted = next_all_healthy(req, chan, good);
    healthy_q.push_back(use_typed ? typed_healthy : predicted);
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic want;
    if (rst_n && out_tvalid && out_tready) begin
      if (healthy_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected result: out_tdata=%h", out_tdata);
      end else begin
        want = healthy_q.pop_front();
        if (out_tdata !== {7'b0, want}) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch at %0t: expected all_healthy=%b, got out_tdata=%h",
                     $realtime, want, out_tdata);
        end
      end
    end
  end

  initial begin
    limit_set_t cur_set;
    int         r;
    logic [1:0] req;
    logic [1:0] chan;
    logic       good;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;

    tick_cnt = '0;
    for (int c = 0; c < mchw_pkg::NUM_CH; c++) begin
      beat_stamp[c] = '0;
      report_stamp[c] = '0;
      report_ok[c] = 1'b1;
    end
    beat_limit   = '{mchw_pkg::LIMIT_FAST, mchw_pkg::LIMIT_FAST, mchw_pkg::LIMIT_SLOW};
    report_limit = '{mchw_pkg::LIMIT_FAST, mchw_pkg::LIMIT_FAST, mchw_pkg::LIMIT_SLOW};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    cur_set = LIM_RESET;
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].lim != cur_set) begin
        drain();
        cur_set = DIRECTED[i].lim;
        for (int c = 0; c < mchw_pkg::NUM_CH; c++) begin
          beat_limit[c]   = (cur_set == LIM_MAX) ? LIMIT_MAX : '0;
          report_limit[c] = (cur_set == LIM_MAX) ? LIMIT_MAX : '0;
        end
        program_limits();
      end
      send_req(DIRECTED[i].req, DIRECTED[i].chan, DIRECTED[i].good, 1'b1, DIRECTED[i].healthy);
    end

    for (int p = 0; p < 7; p++) begin
      drain();
      for (int c = 0; c < mchw_pkg::NUM_CH; c++) begin
        case (p % 3)
          0: begin
            beat_limit[c]   = $urandom_range(0, 15);
            report_limit[c] = $urandom_range(0, 15);
          end
          1: begin
            beat_limit[c]   = $urandom_range(0, 80);
            report_limit[c] = $urandom_range(0, 80);
          end
          default: begin
            r = $urandom_range(0, 2);
            beat_limit[c]   = (r == 0) ? '0 : (r == 1) ? LIMIT_MAX : $urandom();
            r = $urandom_range(0, 2);
            report_limit[c] = (r == 0) ? '0 : (r == 1) ? LIMIT_MAX : $urandom();
          end
        endcase
      end
      program_limits();
      calm = ($urandom_range(0, 3) == 0);
      repeat (100) begin
        r = $urandom_range(0, 99);
        good = $urandom_range(0, 1);
        if (r < 40) begin
          req  = mchw_pkg::REQ_TICK;
          chan = $urandom_range(0, 3);
        end else if (r < 70) begin
          req  = mchw_pkg::REQ_BEAT;
          chan = ($urandom_range(0, 9) == 0) ? CH_OUT_OF_RANGE : $urandom_range(0, 2);
        end else if (r < 95) begin
          req  = mchw_pkg::REQ_REPORT;
          chan = ($urandom_range(0, 9) == 0) ? CH_OUT_OF_RANGE : $urandom_range(0, 2);
          good = ($urandom_range(0, 7) != 0);
        end else begin
          req  = REQ_UNUSED;
          chan = $urandom_range(0, 3);
        end
        send_req(req, chan, good, 1'b0, 1'b0);
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (mismatch_cnt == 0 && healthy_q.size() == 0) begin
      $display("multi_channel_health_watchdog_unit test passed");
    end else begin
      $display("multi_channel_health_watchdog_unit test failed");
    end
    $finish;
  end

endmodule
